>>> hw/rtl/kjg_pkg.sv
package kjg_pkg;

    // default sizes
    localparam int KEY_SLOTS_DEF   = 6;
    localparam int PAD_COUNT_DEF   = 2;
    localparam int PAD_BUTTONS_DEF = 12;

    // width of the button word seen on the result channel
    localparam int WORD_W = 12;

    // event function codes
    localparam logic [2:0] FUNC_KEY_PRESS   = 3'd0;
    localparam logic [2:0] FUNC_KEY_RELEASE = 3'd1;
    localparam logic [2:0] FUNC_BTN_PRESS   = 3'd2;
    localparam logic [2:0] FUNC_BTN_RELEASE = 3'd3;
    localparam logic [2:0] FUNC_HAT         = 3'd4;
    localparam logic [2:0] FUNC_AXIS        = 3'd5;

    // axis select codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_PAD0_AXIS_AS_HAT = 2'd0;
    localparam logic [1:0] CFG_PAD1_AXIS_AS_HAT = 2'd1;
    localparam logic [1:0] CFG_HAT_THRESHOLD    = 2'd2;

    localparam logic [6:0] HAT_THRESHOLD_RESET = 7'd30;

    // modifier usage codes
    localparam logic [7:0] KEY_LCTRL  = 8'hE0;
    localparam logic [7:0] KEY_LSHIFT = 8'd225;
    localparam logic [7:0] KEY_LALT   = 8'd226;
    localparam logic [7:0] KEY_RCTRL  = 8'hE4;
    localparam logic [7:0] KEY_RSHIFT = 8'd229;
    localparam logic [7:0] KEY_RALT   = 8'd230;

    // modifier byte bit positions
    localparam int MOD_LCTRL  = 0;
    localparam int MOD_LSHIFT = 1;
    localparam int MOD_LALT   = 2;
    localparam int MOD_RCTRL  = 4;
    localparam int MOD_RSHIFT = 5;
    localparam int MOD_RALT   = 6;

    // button word bit positions
    localparam int BTN_L     = 4;
    localparam int BTN_R     = 5;
    localparam int BTN_UP    = 8;
    localparam int BTN_DOWN  = 9;
    localparam int BTN_LEFT  = 10;
    localparam int BTN_RIGHT = 11;

    // hat field bit positions
    localparam int HAT_UP    = 0;
    localparam int HAT_RIGHT = 1;
    localparam int HAT_DOWN  = 2;
    localparam int HAT_LEFT  = 3;

    // key codes that drive pad 0 bits, bit i from entry i
    localparam int PAD_KEY_COUNT = 12;
    localparam logic [7:0] PAD_KEY_CODES [PAD_KEY_COUNT] = '{
        8'h07, 8'h09, 8'h08, 8'h15, 8'hE0, 8'hE4,
        8'h2C, 8'h28, 8'h52, 8'h51, 8'h50, 8'h4F
    };

    // one input item
    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         key_code;
        logic [7:0]         pad_index;
        logic [7:0]         button_index;
        logic [3:0]         hat_bits;
        logic [1:0]         axis_select;
        logic signed [15:0] axis_value;
    } kjg_event_t;

    // configuration seen by the pad state
    typedef struct packed {
        logic       pad0_axis_as_hat;
        logic       pad1_axis_as_hat;
        logic [6:0] hat_threshold;
    } kjg_cfg_t;

    // modifier bit for a usage code, zero for ordinary keys
    function automatic logic [6:0] mod_mask(input logic [7:0] code);
        logic [6:0] m;
        m = '0;
        case (code)
            KEY_LCTRL:  m[MOD_LCTRL]  = 1'b1;
            KEY_LSHIFT: m[MOD_LSHIFT] = 1'b1;
            KEY_LALT:   m[MOD_LALT]   = 1'b1;
            KEY_RCTRL:  m[MOD_RCTRL]  = 1'b1;
            KEY_RSHIFT: m[MOD_RSHIFT] = 1'b1;
            KEY_RALT:   m[MOD_RALT]   = 1'b1;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/kjg_if.sv
// event channel
interface kjg_evt_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [7:0]         key_code;
    logic [7:0]         pad_index;
    logic [7:0]         button_index;
    logic [3:0]         hat_bits;
    logic [1:0]         axis_select;
    logic signed [15:0] axis_value;

    modport source (
        output valid, func, key_code, pad_index, button_index, hat_bits,
               axis_select, axis_value,
        input  ready
    );
    modport sink (
        input  valid, func, key_code, pad_index, button_index, hat_bits,
               axis_select, axis_value,
        output ready
    );
endinterface

// result channel
interface kjg_status_if;
    logic        valid;
    logic        ready;
    logic [11:0] pad_a_buttons;
    logic [11:0] pad_b_buttons;
    logic [6:0]  modifier_bits;

    modport source (
        output valid, pad_a_buttons, pad_b_buttons, modifier_bits,
        input  ready
    );
    modport sink (
        input  valid, pad_a_buttons, pad_b_buttons, modifier_bits,
        output ready
    );
endinterface

// configuration write channel
interface kjg_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> hw/rtl/kjg_key_table.sv
module kjg_key_table #(
    parameter int KEY_SLOTS = kjg_pkg::KEY_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               update,
    input  kjg_pkg::kjg_event_t item,
    output logic [11:0]        key_bits,
    output logic [6:0]         modifier_bits
);
    import kjg_pkg::*;

    logic [7:0] slots_reg  [KEY_SLOTS];
    logic [7:0] slots_next [KEY_SLOTS];
    logic [6:0] mod_reg;
    logic [6:0] mod_next;

    // key press or release against modifiers and the slot table
    always_comb
    begin
        logic [6:0] mm;
        logic       press;
        logic       release_key;
        logic       done;
        mm          = mod_mask(item.key_code);
        press       = (item.func == FUNC_KEY_PRESS);
        release_key = (item.func == FUNC_KEY_RELEASE);
        done        = 1'b0;
        mod_next    = mod_reg;
        for (int k = 0; k < KEY_SLOTS; k++)
        begin
            slots_next[k] = slots_reg[k];
        end
        if (press || release_key)
        begin
            if (mm != '0)
            begin
                mod_next = press ? (mod_reg | mm) : (mod_reg & ~mm);
            end
            else
            begin
                // first empty slot on press, first match on release
                for (int k = 0; k < KEY_SLOTS; k++)
                begin
                    if (!done)
                    begin
                        if (press && slots_reg[k] == 8'd0)
                        begin
                            slots_next[k] = item.key_code;
                            done          = 1'b1;
                        end
                        else if (release_key && slots_reg[k] == item.key_code)
                        begin
                            slots_next[k] = 8'd0;
                            done          = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // pad 0 bits from held keys and control modifiers
    always_comb
    begin
        key_bits = '0;
        for (int i = 0; i < PAD_KEY_COUNT; i++)
        begin
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                if (slots_next[k] == PAD_KEY_CODES[i])
                begin
                    key_bits[i] = 1'b1;
                end
            end
        end
        if (mod_next[MOD_LCTRL])
        begin
            key_bits[BTN_L] = 1'b1;
        end
        if (mod_next[MOD_RCTRL])
        begin
            key_bits[BTN_R] = 1'b1;
        end
    end

    assign modifier_bits = mod_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= '0;
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                slots_reg[k] <= 8'd0;
            end
        end
        else if (update)
        begin
            mod_reg <= mod_next;
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                slots_reg[k] <= slots_next[k];
            end
        end
    end

endmodule

>>> hw/rtl/kjg_joy_state.sv
module kjg_joy_state #(
    parameter int PAD_COUNT   = kjg_pkg::PAD_COUNT_DEF,
    parameter int PAD_BUTTONS = kjg_pkg::PAD_BUTTONS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  kjg_pkg::kjg_event_t item,
    input  kjg_pkg::kjg_cfg_t   cfg,
    output logic [11:0]         pad_a_word,
    output logic [11:0]         pad_b_word
);
    import kjg_pkg::*;

    logic [PAD_BUTTONS-1:0] joy_reg  [PAD_COUNT];
    logic [PAD_BUTTONS-1:0] joy_next [PAD_COUNT];
    logic signed [7:0]      ax_reg   [PAD_COUNT];
    logic signed [7:0]      ax_next  [PAD_COUNT];
    logic signed [7:0]      ay_reg   [PAD_COUNT];
    logic signed [7:0]      ay_next  [PAD_COUNT];
    logic [PAD_BUTTONS-1:0] bmask;
    logic signed [8:0]      thr_pos;
    logic signed [8:0]      thr_neg;

    // button decode, out of range indexes give no bit
    always_comb
    begin
        for (int b = 0; b < PAD_BUTTONS; b++)
        begin
            bmask[b] = (item.button_index == 8'(b));
        end
    end

    assign thr_pos = $signed({2'b00, cfg.hat_threshold});
    assign thr_neg = -thr_pos;

    // per pad event update, then axes to direction bits
    always_comb
    begin
        logic                   sel;
        logic                   hat_on;
        logic [PAD_BUTTONS-1:0] w;
        logic signed [7:0]      ax;
        logic signed [7:0]      ay;
        logic signed [8:0]      ax9;
        logic signed [8:0]      ay9;
        for (int p = 0; p < PAD_COUNT; p++)
        begin
            sel = (item.pad_index == 8'(p));
            w   = joy_reg[p];
            ax  = ax_reg[p];
            ay  = ay_reg[p];
            if (sel)
            begin
                case (item.func)
                    FUNC_BTN_PRESS:   w = w | bmask;
                    FUNC_BTN_RELEASE: w = w & ~bmask;
                    FUNC_HAT:
                    begin
                        w[BTN_UP]    = item.hat_bits[HAT_UP];
                        w[BTN_RIGHT] = item.hat_bits[HAT_RIGHT];
                        w[BTN_DOWN]  = item.hat_bits[HAT_DOWN];
                        w[BTN_LEFT]  = item.hat_bits[HAT_LEFT];
                    end
                    FUNC_AXIS:
                    begin
                        if (item.axis_select == AXIS_X)
                        begin
                            ax = item.axis_value[15:8];
                        end
                        else if (item.axis_select == AXIS_Y)
                        begin
                            ay = item.axis_value[15:8];
                        end
                    end
                    default: ;
                endcase
            end
            hat_on = (p == 0) ? cfg.pad0_axis_as_hat :
                     (p == 1) ? cfg.pad1_axis_as_hat : 1'b0;
            ax9 = $signed({ax[7], ax});
            ay9 = $signed({ay[7], ay});
            if (hat_on)
            begin
                w[BTN_LEFT]  = (ax9 < thr_neg);
                w[BTN_RIGHT] = (ax9 > thr_pos);
                w[BTN_UP]    = (ay9 < thr_neg);
                w[BTN_DOWN]  = (ay9 > thr_pos);
            end
            joy_next[p] = w;
            ax_next[p]  = ax;
            ay_next[p]  = ay;
        end
    end

    // result words
    assign pad_a_word = joy_next[0][WORD_W-1:0];

    generate
        if (PAD_COUNT > 1)
        begin : g_pad_b
            assign pad_b_word = joy_next[1][WORD_W-1:0];
        end
        else
        begin : g_no_pad_b
            assign pad_b_word = '0;
        end
    endgenerate

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                joy_reg[p] <= '0;
                ax_reg[p]  <= '0;
                ay_reg[p]  <= '0;
            end
        end
        else if (update)
        begin
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                joy_reg[p] <= joy_next[p];
                ax_reg[p]  <= ax_next[p];
                ay_reg[p]  <= ay_next[p];
            end
        end
    end

endmodule

>>> hw/rtl/keyboard_joystick_to_gamepad_unit.sv
// channel   role    handshake        payload
// evt       sink    valid / ready    func, key_code, pad_index, button_index,
//                                    hat_bits, axis_select, axis_value
// status    source  valid / ready    pad_a_buttons, pad_b_buttons, modifier_bits
// cfg       sink    valid / ready    index, data
//
// One item per cycle sustained while status is not stalled; status valid follows
// evt acceptance through the input register, then the result register.
// The key table and pad state update in the same cycle the item leaves the
// input register, so the next item sees them at once.
// Reset clears the key table, modifiers, pad words, axes and configuration
// (threshold 30). A stalled status channel holds the result register and,
// once the input register is also full, drops evt ready. cfg is always ready.
module keyboard_joystick_to_gamepad_unit #(
    parameter int KEY_SLOTS   = kjg_pkg::KEY_SLOTS_DEF,
    parameter int PAD_COUNT   = kjg_pkg::PAD_COUNT_DEF,
    parameter int PAD_BUTTONS = kjg_pkg::PAD_BUTTONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    kjg_evt_if.sink      evt,
    kjg_status_if.source status,
    kjg_cfg_if.sink      cfg
);
    import kjg_pkg::*;

    logic        evt_valid_reg;
    logic        evt_valid_next;
    kjg_event_t  evt_reg;
    logic        status_valid_reg;
    logic        status_valid_next;
    logic [11:0] pad_a_reg;
    logic [11:0] pad_b_reg;
    logic [6:0]  mod_reg;
    kjg_cfg_t    cfg_reg;
    logic        advance;
    logic        evt_take;
    logic [11:0] key_bits;
    logic [6:0]  mod_bits;
    logic [11:0] pad_a_word;
    logic [11:0] pad_b_word;

    // handshake control
    assign advance           = evt_valid_reg && (!status_valid_reg || status.ready);
    assign evt.ready         = !evt_valid_reg || advance;
    assign evt_take          = evt.valid && evt.ready;
    assign evt_valid_next    = evt_take || (evt_valid_reg && !advance);
    assign status_valid_next = advance || (status_valid_reg && !status.ready);
    assign cfg.ready         = 1'b1;

    // keyboard side
    kjg_key_table #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_key_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .update        (advance),
        .item          (evt_reg),
        .key_bits      (key_bits),
        .modifier_bits (mod_bits)
    );

    // joystick side
    kjg_joy_state #(
        .PAD_COUNT   (PAD_COUNT),
        .PAD_BUTTONS (PAD_BUTTONS)
    ) u_joy_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .item       (evt_reg),
        .cfg        (cfg_reg),
        .pad_a_word (pad_a_word),
        .pad_b_word (pad_b_word)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg    <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg    <= evt_valid_next;
            status_valid_reg <= status_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pad0_axis_as_hat <= 1'b0;
            cfg_reg.pad1_axis_as_hat <= 1'b0;
            cfg_reg.hat_threshold    <= HAT_THRESHOLD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_PAD0_AXIS_AS_HAT: cfg_reg.pad0_axis_as_hat <= cfg.data[0];
                CFG_PAD1_AXIS_AS_HAT: cfg_reg.pad1_axis_as_hat <= cfg.data[0];
                CFG_HAT_THRESHOLD:    cfg_reg.hat_threshold    <= cfg.data;
                default: ;
            endcase
        end
    end

    // input item register
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_reg.func         <= evt.func;
            evt_reg.key_code     <= evt.key_code;
            evt_reg.pad_index    <= evt.pad_index;
            evt_reg.button_index <= evt.button_index;
            evt_reg.hat_bits     <= evt.hat_bits;
            evt_reg.axis_select  <= evt.axis_select;
            evt_reg.axis_value   <= evt.axis_value;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pad_a_reg <= key_bits | pad_a_word;
            pad_b_reg <= pad_b_word;
            mod_reg   <= mod_bits;
        end
    end

    assign status.valid         = status_valid_reg;
    assign status.pad_a_buttons = pad_a_reg;
    assign status.pad_b_buttons = pad_b_reg;
    assign status.modifier_bits = mod_reg;

endmodule
